// ===== design/trace_ring_page_parser_assert.svh =====
// Assertion shorthands used by the checker file.
// Both macros sample on clk and are disabled while rst is high.
`ifndef TRACE_RING_PAGE_PARSER_ASSERT_SVH
`define TRACE_RING_PAGE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define TRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/trp_pkg.sv =====
`timescale 1ns / 1ps

package trp_pkg;

  // result kinds; padding and bad length double as latched error codes
  localparam logic [2:0] KIND_EVENT         = 3'd0;
  localparam logic [2:0] KIND_PAGE_OK       = 3'd1;
  localparam logic [2:0] KIND_HDR_SHORT     = 3'd2;
  localparam logic [2:0] KIND_SIZE_MISMATCH = 3'd3;
  localparam logic [2:0] KIND_TRUNCATED     = 3'd4;
  localparam logic [2:0] KIND_PADDING       = 3'd5;
  localparam logic [2:0] KIND_BAD_LENGTH    = 3'd6;
  localparam logic [2:0] KIND_OVERSIZE      = 3'd7;
  localparam logic [2:0] ERR_NONE           = 3'd0;

  // low 5 bits of an event header: record length in words or a special type
  localparam logic [4:0] TOL_DATA_MIN    = 5'd2;
  localparam logic [4:0] TOL_DATA_MAX    = 5'd28;
  localparam logic [4:0] TOL_PADDING     = 5'd29;
  localparam logic [4:0] TOL_TIME_EXTEND = 5'd30;
  localparam logic [4:0] TOL_TIME_STAMP  = 5'd31;

  localparam logic [15:0] EV_WITH_IP = 16'd5;

  localparam int HDR_BYTES = 16;
  localparam logic [6:0] EXTEND_SKIP = 7'd4;
  localparam logic [6:0] STAMP_SKIP  = 7'd16;
  localparam logic [6:0] COMMON_BYTES = 7'd8;
  localparam logic [6:0] IP_BYTES    = 7'd8;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  cpu;
    logic [31:0] proc_id;
    logic [15:0] event_kind;
    logic [7:0]  flag_bits;
    logic [7:0]  preempt_depth;
    logic        run_last;
  } trp_result_t;

  // up to two results per byte: an event, then a status
  typedef struct packed {
    logic        ev_valid;
    logic        st_valid;
    trp_result_t ev;
    trp_result_t st;
  } trp_push_t;

endpackage

// ===== design/trp_ifs.sv =====
`timescale 1ns / 1ps

interface trp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] page_byte;
  logic       page_end;
  modport source (output valid, page_byte, page_end, input ready);
  modport sink (input valid, page_byte, page_end, output ready);
endinterface

interface trp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  cpu;
  logic [31:0] proc_id;
  logic [15:0] event_kind;
  logic [7:0]  flag_bits;
  logic [7:0]  preempt_depth;
  logic        run_last;
  modport source (output valid, kind, cpu, proc_id, event_kind, flag_bits,
                  preempt_depth, run_last, input ready);
  modport sink (input valid, kind, cpu, proc_id, event_kind, flag_bits,
                preempt_depth, run_last, output ready);
endinterface

interface trp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] cpu_id;
  modport source (output valid, cpu_id, input ready);
  modport sink (input valid, cpu_id, output ready);
endinterface

// ===== design/trace_ring_page_parser.sv =====
`timescale 1ns / 1ps
// Channel     Role    Payload
// page_in     sink    page_byte, page_end
// result_out  source  kind, cpu, proc_id, event_kind, flag_bits, preempt_depth, run_last
// cfg         sink    cpu_id (always ready)
//
// One byte per cycle sustained; bytes are registered at input, results in the queue.
// A byte ending a record's common fields and the page gives an event, then a status.
// Throughput is set by the 4-entry result queue: input stalls while it has under two
// free entries, i.e. only when result_out is back-pressured.
// rst (synchronous) clears the parser state, the queue and cpu_id; no clearing pass.

module trace_ring_page_parser import trp_pkg::*; #(
  parameter int PAGE_BYTES = 4096
) (
  input  logic     clk,
  input  logic     rst,
  trp_in_if.sink   page_in,
  trp_out_if.source result_out,
  trp_cfg_if.sink  cfg
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_end;
  logic [7:0]  cpu_id;
  logic        room;
  logic        go;
  trp_push_t   push;
  trp_result_t head;

  assign go            = in_valid && room;
  assign page_in.ready = !in_valid || go;
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (page_in.valid && page_in.ready) begin
      in_valid <= 1'b1;
    end else if (go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (page_in.valid && page_in.ready) begin
      in_byte <= page_in.page_byte;
      in_end  <= page_in.page_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_id <= '0;
    end else if (cfg.valid) begin
      cpu_id <= cfg.cpu_id;
    end
  end

  trp_core #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .page_byte (in_byte),
    .page_end  (in_end),
    .cpu_id    (cpu_id),
    .push      (push)
  );

  trp_out_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .valid (result_out.valid),
    .ready (result_out.ready),
    .data  (head)
  );

  assign result_out.kind          = head.kind;
  assign result_out.cpu           = head.cpu;
  assign result_out.proc_id       = head.proc_id;
  assign result_out.event_kind    = head.event_kind;
  assign result_out.flag_bits     = head.flag_bits;
  assign result_out.preempt_depth = head.preempt_depth;
  assign result_out.run_last      = head.run_last;

endmodule

// ===== design/trp_core.sv =====
`timescale 1ns / 1ps

module trp_core import trp_pkg::*; #(
  parameter int PAGE_BYTES = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [7:0] page_byte,
  input  logic       page_end,
  input  logic [7:0] cpu_id,
  output trp_push_t  push
);

  localparam int OFS_W = $clog2(PAGE_BYTES + 2);
  localparam logic [OFS_W-1:0] OFS_MAX      = OFS_W'(PAGE_BYTES);
  localparam logic [OFS_W-1:0] OFS_HDR_LAST = OFS_W'(HDR_BYTES - 1);
  localparam logic [OFS_W-1:0] OFS_HDR      = OFS_W'(HDR_BYTES);

  typedef enum logic [6:0] {
    PH_HDR  = 7'b0000001,
    PH_EVH  = 7'b0000010,
    PH_EXT  = 7'b0000100,
    PH_FLD  = 7'b0001000,
    PH_IP   = 7'b0010000,
    PH_SKIP = 7'b0100000,
    PH_DEAD = 7'b1000000
  } phase_t;

  phase_t           phase, phase_next;
  logic [OFS_W-1:0] page_offset, page_offset_next;
  logic [3:0]       field_idx, field_idx_next;
  logic [6:0]       skip_left, skip_left_next;
  logic [31:0]      declared_size, declared_size_next;
  logic [4:0]       type_lo, type_lo_next;
  logic [63:0]      record_fields, record_fields_next;
  logic [2:0]       error_code, error_code_next;

  logic [4:0]  tol;
  logic [6:0]  skip_dec;
  logic [63:0] rf_new;
  logic [2:0]  status_kind;

  always_comb begin
    phase_next         = phase;
    field_idx_next     = field_idx;
    skip_left_next     = skip_left;
    declared_size_next = declared_size;
    type_lo_next       = type_lo;
    record_fields_next = record_fields;
    error_code_next    = error_code;
    push               = '0;
    status_kind        = KIND_PAGE_OK;

    page_offset_next = (page_offset <= OFS_MAX) ? page_offset + OFS_W'(1) : page_offset;
    tol      = (field_idx == 4'd0) ? page_byte[4:0] : type_lo;
    skip_dec = (skip_left != 7'd0) ? skip_left - 7'd1 : skip_left;
    rf_new   = record_fields;
    rf_new[8*field_idx[2:0] +: 8] = page_byte;

    unique case (phase)
      PH_HDR: begin
        // declared size sits in header bytes 8..11
        if (page_offset[OFS_W-1:2] == (OFS_W-2)'(2)) begin
          declared_size_next[8*page_offset[1:0] +: 8] = page_byte;
        end
        if (page_offset == OFS_HDR_LAST) begin
          phase_next     = PH_EVH;
          field_idx_next = '0;
          type_lo_next   = '0;
        end
      end
      PH_EVH: begin
        field_idx_next = field_idx + 4'd1;
        if (field_idx == 4'd0) begin
          type_lo_next = page_byte[4:0];
        end
        if (field_idx == 4'd3) begin
          if (tol == TOL_PADDING) begin
            error_code_next = KIND_PADDING;
            phase_next      = PH_DEAD;
          end else if (tol == TOL_TIME_EXTEND || tol == TOL_TIME_STAMP) begin
            phase_next     = PH_EXT;
            skip_left_next = (tol == TOL_TIME_EXTEND) ? EXTEND_SKIP : STAMP_SKIP;
          end else if (tol < TOL_DATA_MIN || tol > TOL_DATA_MAX) begin
            error_code_next = KIND_BAD_LENGTH;
            phase_next      = PH_DEAD;
          end else begin
            phase_next         = PH_FLD;
            field_idx_next     = '0;
            record_fields_next = '0;
            // record body is 4*L bytes, common fields take the first 8
            skip_left_next     = {tol, 2'b00} - COMMON_BYTES;
          end
        end
      end
      PH_EXT, PH_SKIP: begin
        skip_left_next = skip_dec;
        if (skip_dec == 7'd0) begin
          phase_next     = PH_EVH;
          field_idx_next = '0;
          type_lo_next   = '0;
        end
      end
      PH_FLD: begin
        record_fields_next = rf_new;
        field_idx_next     = field_idx + 4'd1;
        if (field_idx == 4'd7) begin
          push.ev_valid           = 1'b1;
          push.ev.kind            = KIND_EVENT;
          push.ev.cpu             = cpu_id;
          push.ev.proc_id         = rf_new[63:32];
          push.ev.event_kind      = rf_new[15:0];
          push.ev.flag_bits       = rf_new[23:16];
          push.ev.preempt_depth   = rf_new[31:24];
          push.ev.run_last        = !page_end;
          if (rf_new[15:0] == EV_WITH_IP) begin
            if (skip_left < IP_BYTES) begin
              error_code_next = KIND_BAD_LENGTH;
              phase_next      = PH_DEAD;
            end else begin
              skip_left_next = skip_left - IP_BYTES;
              field_idx_next = '0;
              phase_next     = PH_IP;
            end
          end else if (skip_left == 7'd0) begin
            phase_next     = PH_EVH;
            field_idx_next = '0;
            type_lo_next   = '0;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_IP: begin
        field_idx_next = field_idx + 4'd1;
        if (field_idx == 4'd7) begin
          if (skip_left == 7'd0) begin
            phase_next     = PH_EVH;
            field_idx_next = '0;
            type_lo_next   = '0;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_DEAD: begin
      end
      default: begin
      end
    endcase

    // end-of-page status, judged on the state this byte leaves
    if (page_offset_next > OFS_MAX) begin
      status_kind = KIND_OVERSIZE;
    end else if (phase_next == PH_HDR) begin
      status_kind = KIND_HDR_SHORT;
    end else if (declared_size_next > 32'(page_offset_next - OFS_HDR)) begin
      status_kind = KIND_SIZE_MISMATCH;
    end else if (error_code_next != ERR_NONE) begin
      status_kind = error_code_next;
    end else if ((phase_next == PH_EVH && field_idx_next != 4'd0) ||
                 phase_next == PH_EXT || phase_next == PH_FLD || phase_next == PH_IP) begin
      status_kind = KIND_TRUNCATED;
    end

    if (page_end) begin
      push.st_valid = 1'b1;
      push.st.kind  = status_kind;
      push.st.cpu   = cpu_id;
      push.st.run_last = 1'b1;
      phase_next         = PH_HDR;
      page_offset_next   = '0;
      field_idx_next     = '0;
      skip_left_next     = '0;
      declared_size_next = '0;
      type_lo_next       = '0;
      record_fields_next = '0;
      error_code_next    = ERR_NONE;
    end

    // results only leave for a byte that is taken this cycle
    if (!go) begin
      push.ev_valid = 1'b0;
      push.st_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR;
      page_offset   <= '0;
      field_idx     <= '0;
      skip_left     <= '0;
      declared_size <= '0;
      type_lo       <= '0;
      record_fields <= '0;
      error_code    <= ERR_NONE;
    end else if (go) begin
      phase         <= phase_next;
      page_offset   <= page_offset_next;
      field_idx     <= field_idx_next;
      skip_left     <= skip_left_next;
      declared_size <= declared_size_next;
      type_lo       <= type_lo_next;
      record_fields <= record_fields_next;
      error_code    <= error_code_next;
    end
  end

endmodule

// ===== design/trp_out_queue.sv =====
`timescale 1ns / 1ps

module trp_out_queue import trp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  trp_push_t   push,
  output logic        room,
  output logic        valid,
  input  logic        ready,
  output trp_result_t data
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  trp_result_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] st_ptr;
  logic [1:0]       n_push;
  logic             pop;

  assign valid  = (count != '0);
  assign pop    = valid && ready;
  assign room   = (count <= CNT_W'(DEPTH - 2));
  assign data   = slots[rd_ptr];
  assign n_push = {1'b0, push.ev_valid} + {1'b0, push.st_valid};
  assign st_ptr = wr_ptr + PTR_W'(push.ev_valid);
  assign count_next = count + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.ev_valid) begin
      slots[wr_ptr] <= push.ev;
    end
    if (push.st_valid) begin
      slots[st_ptr] <= push.st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

// ===== design/trp_checker.sv =====
`timescale 1ns / 1ps
`include "trace_ring_page_parser_assert.svh"

module trp_checker import trp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [2:0]  kind,
  input logic [7:0]  cpu,
  input logic [31:0] proc_id,
  input logic [15:0] event_kind,
  input logic [7:0]  flag_bits,
  input logic [7:0]  preempt_depth,
  input logic        run_last
);

  `TRP_ASSERT_NEXT(a_hold, valid && !ready, valid && $stable(kind) && $stable(cpu) && $stable(proc_id) && $stable(event_kind) && $stable(run_last), "stalled result changed")
  `TRP_ASSERT_NOW(a_status_last, valid && kind != KIND_EVENT, run_last, "status item not last of its byte")
  `TRP_ASSERT_NOW(a_status_clean, valid && kind != KIND_EVENT, proc_id == 32'd0 && event_kind == 16'd0 && flag_bits == 8'd0 && preempt_depth == 8'd0, "status item carries event fields")
  `TRP_ASSERT_NEXT(a_pair, valid && ready && !run_last, valid && kind != KIND_EVENT, "status did not follow its event")

endmodule

bind trace_ring_page_parser trp_checker u_trp_checker (
  .clk           (clk),
  .rst           (rst),
  .valid         (result_out.valid),
  .ready         (result_out.ready),
  .kind          (result_out.kind),
  .cpu           (result_out.cpu),
  .proc_id       (result_out.proc_id),
  .event_kind    (result_out.event_kind),
  .flag_bits     (result_out.flag_bits),
  .preempt_depth (result_out.preempt_depth),
  .run_last      (result_out.run_last)
);

// ===== tb/tb_trace_ring_page_parser.sv =====
`timescale 1ns / 1ps

module tb_trace_ring_page_parser;
  import trp_pkg::*;

  localparam int PAGE_LEN = 4096;
  localparam int GAP_PCT = 23;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT = 2000;

  typedef enum logic [2:0] {
    PS_HEADER, PS_EV_HEADER, PS_TIME_SKIP, PS_FIELDS, PS_IP, PS_TAIL, PS_DEAD
  } parse_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  trp_in_if  page_in ();
  trp_out_if result_out ();
  trp_cfg_if cfg ();

  trace_ring_page_parser #(.PAGE_BYTES(PAGE_LEN)) DUT (
    .clk(clk),
    .rst(rst),
    .page_in(page_in),
    .result_out(result_out),
    .cfg(cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser shadow state
  parse_state_t pstate;
  int unsigned  pos;
  int unsigned  fld_idx;
  int unsigned  skip_left;
  logic [31:0]  size_field;
  logic [31:0]  ev_word;
  logic [63:0]  rec_word;
  logic [2:0]   err_latched;
  logic [7:0]   cpu_cfg;

  trp_result_t expected_results[$];
  logic [7:0]  page_q[$];

  bit gaps_on = 1'b1;
  int mismatches;
  int pages_sent;
  int bytes_sent;
  int events_checked;
  int status_checked [8];

  function automatic void clear_page_state();
    pstate = PS_HEADER;
    pos = 0;
    fld_idx = 0;
    skip_left = 0;
    size_field = '0;
    ev_word = '0;
    rec_word = '0;
    err_latched = ERR_NONE;
  endfunction

  function automatic void start_ev_header();
    pstate = PS_EV_HEADER;
    fld_idx = 0;
    ev_word = '0;
  endfunction

  function automatic void latch_error(input logic [2:0] code);
    err_latched = code;
    pstate = PS_DEAD;
  endfunction

  function automatic trp_result_t make_result(input logic [2:0] k, input logic [31:0] pid,
                                              input logic [15:0] ev, input logic [7:0] fl,
                                              input logic [7:0] pc);
    trp_result_t r;
    r.kind = k;
    r.cpu = cpu_cfg;
    r.proc_id = pid;
    r.event_kind = ev;
    r.flag_bits = fl;
    r.preempt_depth = pc;
    r.run_last = 1'b0;
    return r;
  endfunction

  // advance the shadow parser by one byte, queue whatever it emits
  function automatic void parse_page_byte(input logic [7:0] b, input logic last);
    trp_result_t res [2];
    int          n;
    logic [4:0]  tol;
    logic [2:0]  status;
    int unsigned idx;
    n = 0;
    if (pos <= PAGE_LEN) pos++;
    case (pstate)
      PS_HEADER: begin
        idx = pos - 1;
        if (idx >= 8 && idx <= 11) size_field |= 32'(b) << (8 * (idx - 8));
        if (pos >= HDR_BYTES) start_ev_header();
      end
      PS_EV_HEADER: begin
        ev_word |= 32'(b) << (8 * (fld_idx % 4));
        fld_idx++;
        if (fld_idx >= 4) begin
          tol = ev_word[4:0];
          if (tol == TOL_PADDING) begin
            latch_error(KIND_PADDING);
          end else if (tol == TOL_TIME_EXTEND || tol == TOL_TIME_STAMP) begin
            pstate = PS_TIME_SKIP;
            skip_left = (tol == TOL_TIME_EXTEND) ? int'(EXTEND_SKIP) : int'(STAMP_SKIP);
          end else if (tol < TOL_DATA_MIN) begin
            latch_error(KIND_BAD_LENGTH);
          end else begin
            pstate = PS_FIELDS;
            fld_idx = 0;
            rec_word = '0;
            skip_left = 4 * int'(tol) - int'(COMMON_BYTES);
          end
        end
      end
      PS_FIELDS: begin
        rec_word |= 64'(b) << (8 * (fld_idx % 8));
        fld_idx++;
        if (fld_idx >= 8) begin
          res[n] = make_result(KIND_EVENT, rec_word[63:32], rec_word[15:0],
                               rec_word[23:16], rec_word[31:24]);
          n++;
          if (rec_word[15:0] == EV_WITH_IP) begin
            if (skip_left < IP_BYTES) begin
              latch_error(KIND_BAD_LENGTH);
            end else begin
              skip_left -= IP_BYTES;
              fld_idx = 0;
              pstate = PS_IP;
            end
          end else if (skip_left == 0) begin
            start_ev_header();
          end else begin
            pstate = PS_TAIL;
          end
        end
      end
      PS_IP: begin
        fld_idx++;
        if (fld_idx >= 8) begin
          if (skip_left == 0) start_ev_header();
          else pstate = PS_TAIL;
        end
      end
      PS_TIME_SKIP, PS_TAIL: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) start_ev_header();
      end
      default: begin
      end
    endcase

    if (last) begin
      if (pos > PAGE_LEN) status = KIND_OVERSIZE;
      else if (pstate == PS_HEADER) status = KIND_HDR_SHORT;
      else if (size_field > 32'(pos - HDR_BYTES)) status = KIND_SIZE_MISMATCH;
      else if (err_latched != ERR_NONE) status = err_latched;
      else if ((pstate == PS_EV_HEADER && fld_idx != 0) || pstate == PS_TIME_SKIP ||
               pstate == PS_FIELDS || pstate == PS_IP)
        status = KIND_TRUNCATED;
      else status = KIND_PAGE_OK;
      res[n] = make_result(status, '0, '0, '0, '0);
      n++;
      clear_page_state();
    end

    for (int i = 0; i < n; i++) begin
      if (i == n - 1) res[i].run_last = 1'b1;
      expected_results.push_back(res[i]);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // shadow model and result checks share one process so a same-cycle
  // result can never overtake its own prediction
  always @(posedge clk) begin : check_results
    trp_result_t got;
    trp_result_t want;
    if (rst) begin
      clear_page_state();
      cpu_cfg = 8'd0;
    end else begin
      if (cfg.valid && cfg.ready) cpu_cfg = cfg.cpu_id;
      if (page_in.valid && page_in.ready) parse_page_byte(page_in.page_byte, page_in.page_end);
      if (result_out.valid && result_out.ready) begin
        got.kind = result_out.kind;
        got.cpu = result_out.cpu;
        got.proc_id = result_out.proc_id;
        got.event_kind = result_out.event_kind;
        got.flag_bits = result_out.flag_bits;
        got.preempt_depth = result_out.preempt_depth;
        got.run_last = result_out.run_last;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, kind %0d proc_id %0h event_kind %0h",
                   $time, got.kind, got.proc_id, got.event_kind);
        end else begin
          want = expected_results.pop_front();
          if (want.kind == KIND_EVENT) events_checked++;
          else status_checked[want.kind]++;
          check_field("kind", want.kind, got.kind);
          check_field("cpu", want.cpu, got.cpu);
          check_field("proc_id", want.proc_id, got.proc_id);
          check_field("event_kind", want.event_kind, got.event_kind);
          check_field("flag_bits", want.flag_bits, got.flag_bits);
          check_field("preempt_depth", want.preempt_depth, got.preempt_depth);
          check_field("run_last", want.run_last, got.run_last);
        end
      end
    end
  end

  always @(negedge clk) begin
    result_out.ready <= gaps_on ? ($urandom_range(99) >= GAP_PCT) : 1'b1;
  end

  // ---- page building ----

  function automatic void add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) page_q.push_back(w[8*i +: 8]);
  endfunction

  function automatic void start_page();
    page_q.delete();
    repeat (HDR_BYTES) page_q.push_back(8'($urandom));
  endfunction

  function automatic void add_header(input logic [4:0] tol);
    add_word({27'($urandom), tol});
  endfunction

  function automatic void add_record(input int len, input logic [15:0] ev, input logic [7:0] fl,
                                     input logic [7:0] pc, input logic [31:0] pid);
    add_header(5'(len));
    if (len >= 2) begin
      add_word({pc, fl, ev});
      add_word(pid);
      repeat (4 * len - 8) page_q.push_back(8'($urandom));
    end
  endfunction

  function automatic void add_time(input logic [4:0] tol);
    add_header(tol);
    repeat ((tol == TOL_TIME_EXTEND) ? int'(EXTEND_SKIP) : int'(STAMP_SKIP))
      page_q.push_back(8'($urandom));
  endfunction

  function automatic void set_size(input logic [31:0] sz);
    if (page_q.size() >= 12)
      for (int i = 0; i < 4; i++) page_q[8 + i] = sz[8*i +: 8];
  endfunction

  function automatic void trim_page(input int keep);
    while (page_q.size() > keep) void'(page_q.pop_back());
  endfunction

  function automatic void build_random_page();
    int          n_items;
    int          pick;
    int          len;
    logic [31:0] sz;
    start_page();
    pick = $urandom_range(99);
    if (pick < 8) begin
      // raw noise, often shorter than the header
      page_q.delete();
      repeat ($urandom_range(1, 48)) page_q.push_back(8'($urandom));
      if ($urandom_range(1)) set_size(32'd0);
      return;
    end
    n_items = $urandom_range(1, 8);
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        add_time(TOL_TIME_EXTEND);
      end else if (pick < 16) begin
        add_time(TOL_TIME_STAMP);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 28) : $urandom_range(2, 8);
        add_record(len, (pick < 28) ? EV_WITH_IP : 16'($urandom), 8'($urandom),
                   8'($urandom), $urandom);
      end
    end
    pick = $urandom_range(99);
    if (pick >= 94) begin
      repeat ($urandom_range(1, 20)) page_q.push_back(8'($urandom));
    end else if (pick >= 88) begin
      repeat ($urandom_range(1, 3)) page_q.push_back(8'($urandom));
    end else if (pick >= 82) begin
      add_header(5'($urandom_range(1)));
      repeat ($urandom_range(0, 8)) page_q.push_back(8'($urandom));
    end else if (pick >= 75) begin
      add_header(TOL_PADDING);
      repeat ($urandom_range(0, 8)) page_q.push_back(8'($urandom));
    end else if (pick >= 65) begin
      trim_page($urandom_range(HDR_BYTES + 1, page_q.size()));
    end
    sz = page_q.size() - HDR_BYTES;
    pick = $urandom_range(99);
    if (pick < 10) sz = $urandom_range(0, sz);
    else if (pick < 15) sz = sz + $urandom_range(1, 64);
    else if (pick < 20) sz = $urandom;
    set_size(sz);
  endfunction

  // ---- driving ----

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      page_in.valid <= 1'b0;
      @(negedge clk);
    end
    page_in.valid <= 1'b1;
    page_in.page_byte <= b;
    page_in.page_end <= last;
    @(posedge clk);
    while (!page_in.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_page();
    foreach (page_q[i]) send_byte(page_q[i], i == page_q.size() - 1);
    pages_sent++;
    bytes_sent += page_q.size();
  endtask

  task automatic send_cut_page(input int keep);
    trim_page(keep);
    set_size(32'(keep - HDR_BYTES));
    send_page();
  endtask

  // hold off until every queued result is back and the pipeline is quiet
  task automatic wait_idle();
    page_in.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cpu(input logic [7:0] value);
    wait_idle();
    cfg.valid <= 1'b1;
    cfg.cpu_id <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // ---- tests ----

  task automatic test_record_layouts();
    write_cpu(8'h00);
    start_page();
    add_record(2, 16'h0000, 8'h00, 8'h00, 32'h0000_0000);
    add_record(28, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    add_time(TOL_TIME_EXTEND);
    add_time(TOL_TIME_STAMP);
    add_record(4, EV_WITH_IP, 8'h5A, 8'hA5, $urandom);  // ip fills the record
    add_record(7, EV_WITH_IP, 8'($urandom), 8'($urandom), $urandom);
    add_record(2, 16'h1234, 8'($urandom), 8'($urandom), $urandom);  // event + status
    send_cut_page(page_q.size());
    start_page();
    send_cut_page(HDR_BYTES);
    // page ends inside a record tail: fine
    start_page();
    add_record(10, 16'h0042, 8'($urandom), 8'($urandom), $urandom);
    send_cut_page(HDR_BYTES + 4 + 8 + 5);
  endtask

  task automatic test_error_endings();
    write_cpu(8'hFF);
    start_page();
    send_cut_page(10);
    start_page();
    send_cut_page(1);
    start_page();
    add_record(3, 16'($urandom), 8'($urandom), 8'($urandom), $urandom);
    set_size(page_q.size() - HDR_BYTES + 1);
    send_page();
    start_page();
    add_record(2, 16'($urandom), 8'($urandom), 8'($urandom), $urandom);
    set_size(32'hFFFF_FFFF);
    send_page();
    start_page();
    add_record(3, 16'($urandom), 8'($urandom), 8'($urandom), $urandom);
    add_header(TOL_PADDING);
    repeat (6) page_q.push_back(8'($urandom));
    send_cut_page(page_q.size());
    start_page();
    add_header(5'd0);
    repeat (4) page_q.push_back(8'($urandom));
    send_cut_page(page_q.size());
    start_page();
    add_header(5'd1);
    repeat (4) page_q.push_back(8'($urandom));
    send_cut_page(page_q.size());
    // ip does not fit: event first, then bad length
    for (int len = 2; len <= 3; len++) begin
      start_page();
      add_record(len, EV_WITH_IP, 8'($urandom), 8'($urandom), $urandom);
      add_record(2, 16'($urandom), 8'($urandom), 8'($urandom), $urandom);
      send_cut_page(page_q.size());
    end
  endtask

  task automatic test_truncation();
    write_cpu(8'($urandom_range(1, 254)));
    start_page();
    add_record(2, 16'($urandom), 8'($urandom), 8'($urandom), $urandom);
    send_cut_page(HDR_BYTES + 2);       // inside an event header
    start_page();
    add_time(TOL_TIME_STAMP);
    send_cut_page(HDR_BYTES + 4 + 7);   // inside a time stamp
    start_page();
    add_record(6, 16'($urandom), 8'($urandom), 8'($urandom), $urandom);
    send_cut_page(HDR_BYTES + 4 + 5);   // inside the common fields
    start_page();
    add_record(6, EV_WITH_IP, 8'($urandom), 8'($urandom), $urandom);
    send_cut_page(HDR_BYTES + 4 + 8 + 3);  // inside the ip
    start_page();
    add_record(2, 16'($urandom), 8'($urandom), 8'($urandom), $urandom);
    send_cut_page(HDR_BYTES + 4);       // right after a record header
    start_page();
    add_time(TOL_TIME_EXTEND);
    send_cut_page(HDR_BYTES + 4);       // right after a time extend header
  endtask

  task automatic test_random_pages(input int budget, input bit with_gaps);
    int first;
    gaps_on = with_gaps;
    write_cpu(8'($urandom));
    first = bytes_sent;
    while (bytes_sent - first < budget) begin
      build_random_page();
      send_page();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    page_in.valid = 1'b0;
    page_in.page_byte = 8'd0;
    page_in.page_end = 1'b0;
    result_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.cpu_id = 8'd0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_record_layouts();
    test_error_endings();
    test_truncation();
    test_random_pages(550, 1'b1);
    test_random_pages(300, 1'b0);
    test_random_pages(200, 1'b1);

    page_in.valid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && expected_results.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      mismatches += expected_results.size();
    end
    $display("Sent %0d pages (%0d bytes); checked %0d events and page status ok %0d,",
             pages_sent, bytes_sent, events_checked, status_checked[KIND_PAGE_OK]);
    $display("short %0d, size mismatch %0d, truncated %0d,",
             status_checked[KIND_HDR_SHORT], status_checked[KIND_SIZE_MISMATCH],
             status_checked[KIND_TRUNCATED]);
    $display("padding %0d, bad length %0d, oversize %0d",
             status_checked[KIND_PADDING], status_checked[KIND_BAD_LENGTH],
             status_checked[KIND_OVERSIZE]);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
